FILE: design/utf8d_pkg.sv
// Package for the UTF-8 stream decoder: byte classes, status codes,
// the front-to-back item type, result type and sizing constants.
// Used by every module of the decoder; depends on nothing.
`default_nettype none

package utf8d_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned OFF_W           = 16;
  localparam int unsigned CP_W            = 32;
  localparam int unsigned MISS_W          = 3;
  localparam int unsigned STAT_W          = 2;
  localparam int unsigned Q_DEPTH         = 2;
  localparam int unsigned Q_PTR_W         = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W         = $clog2(Q_DEPTH + 1);
  localparam int unsigned MAX_PEND        = 5;

  // Packed master data: code_point, error_offset, bytes_missing, char_count
  localparam int unsigned M_FIELDS_W = CP_W + OFF_W + MISS_W + OFF_W;
  localparam int unsigned M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  // Lead and continuation byte masks
  localparam logic [7:0] MASK_TOP2 = 8'hC0;
  localparam logic [7:0] MASK_TOP3 = 8'hE0;
  localparam logic [7:0] MASK_TOP4 = 8'hF0;
  localparam logic [7:0] MASK_TOP5 = 8'hF8;
  localparam logic [7:0] MASK_TOP6 = 8'hFC;
  localparam logic [7:0] PAT_CONT  = 8'h80;
  localparam logic [7:0] PAT_LEAD2 = 8'hC0;
  localparam logic [7:0] PAT_LEAD3 = 8'hE0;
  localparam logic [7:0] PAT_LEAD4 = 8'hF0;
  localparam logic [7:0] PAT_LEAD5 = 8'hF8;
  localparam logic [7:0] BITS_CONT = 8'h3F;
  localparam logic [7:0] BITS_L2   = 8'h1F;
  localparam logic [7:0] BITS_L3   = 8'h0F;
  localparam logic [7:0] BITS_L4   = 8'h07;
  localparam logic [7:0] BITS_L56  = 8'h03;

  typedef enum logic [1:0] {
    KIND_ASCII,
    KIND_CONT,
    KIND_LEAD
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_CHAR      = 2'd0,
    ST_INVALID   = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  // One classified byte travelling from front to back
  typedef struct packed {
    kind_t             kind;
    logic [6:0]        payload;   // value bits of the byte, masked
    logic [MISS_W-1:0] len;       // continuation bytes a lead opens
    logic              eos;
  } item_t;

  typedef struct packed {
    logic [CP_W-1:0]   code_point;
    status_t           status;
    logic [OFF_W-1:0]  error_offset;
    logic [MISS_W-1:0] bytes_missing;
    logic [OFF_W-1:0]  char_count;
    logic              last_result;
  } result_t;

endpackage

`default_nettype wire

FILE: design/utf8d_front.sv
// Front stage: accepts input bytes, classifies them (ASCII, continuation,
// lead with its length) and holds one classified item. Uses utf8d_pkg.
`default_nettype none

module utf8d_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_eos,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output utf8d_pkg::item_t     out_item
);
  import utf8d_pkg::*;

  item_t cls;
  logic  valid;
  item_t item;

  always_comb begin
    cls.eos     = in_eos;
    cls.len     = '0;
    cls.payload = '0;
    cls.kind    = KIND_LEAD;
    if (!in_byte[7]) begin
      cls.kind    = KIND_ASCII;
      cls.payload = in_byte[6:0];
    end else if ((in_byte & MASK_TOP2) == PAT_CONT) begin
      cls.kind    = KIND_CONT;
      cls.payload = 7'(in_byte & BITS_CONT);
    end else if ((in_byte & MASK_TOP3) == PAT_LEAD2) begin
      cls.len     = 3'd1;
      cls.payload = 7'(in_byte & BITS_L2);
    end else if ((in_byte & MASK_TOP4) == PAT_LEAD3) begin
      cls.len     = 3'd2;
      cls.payload = 7'(in_byte & BITS_L3);
    end else if ((in_byte & MASK_TOP5) == PAT_LEAD4) begin
      cls.len     = 3'd3;
      cls.payload = 7'(in_byte & BITS_L4);
    end else if ((in_byte & MASK_TOP6) == PAT_LEAD5) begin
      cls.len     = 3'd4;
      cls.payload = 7'(in_byte & BITS_L56);
    end else begin
      // 0xFC..0xFF all open six-byte sequences
      cls.len     = 3'd5;
      cls.payload = 7'(in_byte & BITS_L56);
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= cls;
    end
  end

endmodule

`default_nettype wire

FILE: design/utf8d_queue.sv
// Short FIFO of classified items between front and back stages.
// Uses utf8d_pkg for the item type and depth.
`default_nettype none

module utf8d_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire utf8d_pkg::item_t push_item,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output utf8d_pkg::item_t     pop_item
);
  import utf8d_pkg::*;

  item_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;
  logic                push;
  logic                pop;

  assign push_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: design/utf8d_back.sv
// Back stage: per-string decode state, sequence assembly, error and
// truncation handling, and the result output register. Uses utf8d_pkg.
`default_nettype none

module utf8d_back #(
  parameter int unsigned COUNT_WIDTH = utf8d_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire utf8d_pkg::item_t in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output utf8d_pkg::result_t    out_res
);
  import utf8d_pkg::*;

  localparam int unsigned CNT_W = (COUNT_WIDTH < OFF_W) ? COUNT_WIDTH : OFF_W;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic [CP_W-1:0]   acc,       acc_next;
  logic [MISS_W-1:0] pending,   pending_next;
  logic [CNT_W-1:0]  seq_start, seq_start_next;
  logic [CNT_W-1:0]  offset,    offset_next;
  logic [CNT_W-1:0]  count,     count_next;
  logic              stopped,   stopped_next;
  logic              res_valid;
  result_t           res;
  logic              take;
  result_t           res_reg;
  logic              res_reg_valid;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  assign in_ready  = !res_reg_valid || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = res_reg_valid;
  assign out_res   = res_reg;

  always_comb begin
    logic [CP_W-1:0]   acc_sh;
    logic [MISS_W-1:0] pend_dec;
    acc_sh   = {acc[CP_W-7:0], in_item.payload[5:0]};
    pend_dec = pending - 1'b1;

    acc_next       = acc;
    pending_next   = pending;
    seq_start_next = seq_start;
    offset_next    = offset;
    count_next     = count;
    stopped_next   = stopped;
    res_valid      = 1'b0;
    res            = '0;
    res.status     = ST_CHAR;

    if (stopped) begin
      offset_next = sat_inc(offset);
    end else begin
      if (pending == '0) begin
        case (in_item.kind)
          KIND_ASCII: begin
            count_next      = sat_inc(count);
            res_valid       = 1'b1;
            res.code_point  = CP_W'(in_item.payload);
            res.last_result = in_item.eos;
          end
          KIND_CONT: begin
            // continuation with no open sequence
            res_valid        = 1'b1;
            res.status       = ST_INVALID;
            res.error_offset = OFF_W'(offset);
            res.last_result  = 1'b1;
            stopped_next     = 1'b1;
          end
          KIND_LEAD: begin
            seq_start_next = offset;
            pending_next   = in_item.len;
            acc_next       = CP_W'(in_item.payload);
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end else if (in_item.kind == KIND_CONT) begin
        pending_next = pend_dec;
        acc_next     = acc_sh;
        if (pend_dec == '0) begin
          count_next      = sat_inc(count);
          res_valid       = 1'b1;
          res.code_point  = acc_sh;
          res.last_result = in_item.eos;
          acc_next        = '0;
        end
      end else begin
        // sequence broken by a non-continuation byte
        res_valid        = 1'b1;
        res.status       = ST_INVALID;
        res.error_offset = OFF_W'(seq_start);
        res.last_result  = 1'b1;
        stopped_next     = 1'b1;
        pending_next     = '0;
        acc_next         = '0;
      end
      if (!in_item.eos) begin
        offset_next = sat_inc(offset);
      end else if (!res_valid) begin
        res_valid         = 1'b1;
        res.status        = ST_TRUNCATED;
        res.error_offset  = OFF_W'(seq_start_next);
        res.bytes_missing = pending_next;
        res.last_result   = 1'b1;
      end
    end
    res.char_count = OFF_W'(count_next);

    if (in_item.eos) begin
      acc_next       = '0;
      pending_next   = '0;
      seq_start_next = '0;
      offset_next    = '0;
      count_next     = '0;
      stopped_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      pending       <= '0;
      seq_start     <= '0;
      offset        <= '0;
      count         <= '0;
      stopped       <= 1'b0;
      res_reg_valid <= 1'b0;
    end else begin
      if (take) begin
        acc       <= acc_next;
        pending   <= pending_next;
        seq_start <= seq_start_next;
        offset    <= offset_next;
        count     <= count_next;
        stopped   <= stopped_next;
      end
      if (in_ready) begin
        res_reg_valid <= take && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      res_reg <= res;
    end
  end

  a_stopped_no_seq: assert property (@(posedge clk) disable iff (rst)
    stopped |-> (pending == '0) && (acc == '0))
    else $error("sequence state left open after error");

  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    pending <= MISS_W'(MAX_PEND))
    else $error("pending continuation count out of range");

  a_error_ends_string: assert property (@(posedge clk) disable iff (rst)
    res_reg_valid && (res_reg.status != ST_CHAR) |->
      res_reg.last_result && (res_reg.code_point == '0))
    else $error("error result not final or carries a code point");

  a_char_clean: assert property (@(posedge clk) disable iff (rst)
    res_reg_valid && (res_reg.status == ST_CHAR) |->
      (res_reg.error_offset == '0) && (res_reg.bytes_missing == '0))
    else $error("character result carries error fields");

endmodule

`default_nettype wire

FILE: design/utf8_stream_decoder.sv
// UTF-8 stream decoder: one byte per request in, at most one result out.
// Path: a byte accepted on s_* passes the front register, the queue and the
//   result register, in that order, before its result shows on m_*.
// Throughput: one byte per cycle sustained; s_tready only drops when the
//   queue and front register have filled behind a stalled m_tready.
// Reset: rst is synchronous, active high; clears string state, empties the pipeline.
`default_nettype none

module utf8_stream_decoder #(
  // Width of the saturating offset and character counters (8..32);
  // counters never go beyond 65535.
  parameter int unsigned COUNT_WIDTH = utf8d_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Byte input
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  wire logic                           s_tlast,   // end_of_string
  // Result output
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [utf8d_pkg::M_DATA_W-1:0]      m_tdata,   // [31:0] code_point,
                                                         // [47:32] error_offset,
                                                         // [50:48] bytes_missing,
                                                         // [66:51] char_count,
                                                         // upper bits zero
  output logic [utf8d_pkg::STAT_W-1:0]        m_tuser,   // [1:0] status
  output logic                                m_tlast    // last_result
);
  import utf8d_pkg::*;

  // Front: register + classify
  logic    f_valid;
  logic    f_ready;
  item_t   f_item;
  // Queue head
  logic    q_valid;
  logic    q_ready;
  item_t   q_item;
  // Result register
  result_t res;

  utf8d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_eos    (s_tlast),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  // Decouples classification from decode so each side stalls on its own
  utf8d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Decode state; accepts a new item whenever the result slot is free or
  // being drained this cycle, so back-to-back bytes flow at full rate.
  utf8d_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = M_DATA_W'({res.char_count, res.bytes_missing,
                              res.error_offset, res.code_point});
  assign m_tuser = res.status;
  assign m_tlast = res.last_result;

endmodule

`default_nettype wire

FILE: tb/tb_utf8_stream_decoder.sv
// Self-checking testbench for utf8_stream_decoder: directed byte table and random strings
// with random stalls on both streams, and between them one long string with no idling.
// Depends on utf8d_pkg and utf8_stream_decoder only.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
  import utf8d_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BYTES = 1570;
  localparam int LONG_ASCII   = 200;    // long string sent with no idling on either side
  localparam int DRAIN_CYCLES = 8;      // pipeline is 3 deep, give it some margin
  localparam logic [15:0] CNT_MAX =
      (COUNT_WIDTH_DEF >= 16) ? 16'hFFFF : 16'((1 << COUNT_WIDTH_DEF) - 1);

  typedef struct {
    logic [7:0] b;
    logic       eos;
    bit         typed;   // expected result typed in the table, not predicted
    result_t    want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata  = 8'h00;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]   m_tuser;
  logic                m_tlast;

  always #2 clk = ~clk;

  utf8_stream_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Decoder image kept by the testbench, updated per accepted byte
  logic [31:0] cp_acc     = '0;
  logic [2:0]  cont_left  = '0;
  logic [15:0] seq_origin = '0;
  logic [15:0] str_offset = '0;
  logic [15:0] chars_seen = '0;
  bit          dropping   = 1'b0;

  result_t     results_due [$];
  script_row_t script [$];
  int          errors    = 0;
  int          cycles    = 0;
  bit          steady    = 1'b0;   // no idling on either side while set
  int          src_calm  = 0;
  int          sink_calm = 0;

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v >= CNT_MAX) ? CNT_MAX : v + 16'd1;
  endfunction

  function automatic result_t fixed_result(input logic [31:0] cp, input status_t st,
                                           input logic [15:0] off, input logic [2:0] miss,
                                           input logic [15:0] cnt, input logic last);
    result_t r;
    r.code_point    = cp;
    r.status        = st;
    r.error_offset  = off;
    r.bytes_missing = miss;
    r.char_count    = cnt;
    r.last_result   = last;
    return r;
  endfunction

  // Lead byte of a well-formed sequence of len bytes, random value bits
  function automatic logic [7:0] lead_for(input int len);
    case (len)
      1: return 8'($urandom_range(0, 127));
      2: return PAT_LEAD2 | 8'($urandom_range(0, 31));
      3: return PAT_LEAD3 | 8'($urandom_range(0, 15));
      4: return PAT_LEAD4 | 8'($urandom_range(0, 7));
      5: return PAT_LEAD5 | 8'($urandom_range(0, 3));
      default: return MASK_TOP6 | 8'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return PAT_CONT | 8'($urandom_range(0, 63));
  endfunction

  // One accepted byte through the decoder image; has is set when a result is due
  task automatic decode_byte(input logic [7:0] b, input logic eos,
                             output bit has, output result_t r);
    logic [15:0] here;
    here = str_offset;
    has  = 1'b0;
    r    = '0;
    if (dropping) begin
      // rest of a failed string: no result, string end clears everything
      if (eos) begin
        {cp_acc, cont_left, seq_origin, str_offset, chars_seen, dropping} = '0;
      end else begin
        str_offset = bump(str_offset);
      end
      return;
    end
    if (cont_left == 0) begin
      if (b < PAT_CONT) begin
        chars_seen = bump(chars_seen);
        r   = fixed_result({24'h0, b}, ST_CHAR, 16'h0, 3'h0, chars_seen, eos);
        has = 1'b1;
      end else if ((b & MASK_TOP2) == PAT_CONT) begin
        // stray continuation, reported at its own offset
        r        = fixed_result(32'h0, ST_INVALID, here, 3'h0, chars_seen, 1'b1);
        has      = 1'b1;
        dropping = 1'b1;
      end else begin
        seq_origin = here;
        if ((b & MASK_TOP3) == PAT_LEAD2) begin
          cont_left = 3'd1; cp_acc = 32'(b & BITS_L2);
        end else if ((b & MASK_TOP4) == PAT_LEAD3) begin
          cont_left = 3'd2; cp_acc = 32'(b & BITS_L3);
        end else if ((b & MASK_TOP5) == PAT_LEAD4) begin
          cont_left = 3'd3; cp_acc = 32'(b & BITS_L4);
        end else if ((b & MASK_TOP6) == PAT_LEAD5) begin
          cont_left = 3'd4; cp_acc = 32'(b & BITS_L56);
        end else begin
          cont_left = 3'd5; cp_acc = 32'(b & BITS_L56);
        end
      end
    end else if ((b & MASK_TOP2) == PAT_CONT) begin
      cp_acc    = {cp_acc[25:0], b[5:0]};
      cont_left = cont_left - 3'd1;
      if (cont_left == 0) begin
        chars_seen = bump(chars_seen);
        r      = fixed_result(cp_acc, ST_CHAR, 16'h0, 3'h0, chars_seen, eos);
        has    = 1'b1;
        cp_acc = '0;
      end
    end else begin
      // bad continuation: blame the sequence start, the byte itself is not decoded
      r         = fixed_result(32'h0, ST_INVALID, seq_origin, 3'h0, chars_seen, 1'b1);
      has       = 1'b1;
      dropping  = 1'b1;
      cont_left = '0;
      cp_acc    = '0;
    end
    if (eos) begin
      if (!has) begin
        r   = fixed_result(32'h0, ST_TRUNCATED, seq_origin, cont_left, chars_seen, 1'b1);
        has = 1'b1;
      end
      {cp_acc, cont_left, seq_origin, str_offset, chars_seen, dropping} = '0;
    end else begin
      str_offset = bump(str_offset);
    end
  endtask

  // Idle length for either side: mostly none or short, some long, plus calm stretches
  task automatic pick_idle(inout int calm, output int n);
    int r;
    n = 0;
    if (steady) return;
    if (calm > 0) begin
      calm--;
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 80);
    else if (r < 50) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 40);
  endtask

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Send one byte request; on acceptance queue the typed or predicted result
  task automatic send_byte(input logic [7:0] b, input logic eos,
                           input bit typed = 1'b0, input result_t want = '0);
    int      gap;
    bit      has;
    result_t r;
    pick_idle(src_calm, gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    decode_byte(b, eos, has, r);
    if (typed) results_due.push_back(want);
    else if (has) results_due.push_back(r);
  endtask

  task automatic script_row(input logic [7:0] b, input logic eos,
                            input bit typed = 1'b0, input result_t want = '0);
    script.push_back('{b, eos, typed, want});
  endtask

  // Result side: random stalls on m_tready, check every accepted result
  always @(posedge clk) begin : result_sink
    int      stall;
    result_t want;
    bit      bad;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          flag_error($sformatf("result with none pending: cp=%h st=%0d off=%0d miss=%0d cnt=%0d last=%0d",
                               m_tdata[31:0], m_tuser, m_tdata[47:32], m_tdata[50:48],
                               m_tdata[66:51], m_tlast));
        end else begin
          want = results_due.pop_front();
          bad  = (m_tdata[31:0]  !== want.code_point)    ||
                 (m_tuser        !== want.status)        ||
                 (m_tdata[47:32] !== want.error_offset)  ||
                 (m_tdata[50:48] !== want.bytes_missing) ||
                 (m_tdata[66:51] !== want.char_count)    ||
                 (m_tlast        !== want.last_result)   ||
                 (m_tdata[M_DATA_W-1:67] !== '0);
          if (bad)
            flag_error($sformatf({"mismatch: exp cp=%h st=%0d off=%0d miss=%0d cnt=%0d last=%0d",
                                  " got cp=%h st=%0d off=%0d miss=%0d cnt=%0d last=%0d pad=%h"},
                                 want.code_point, want.status, want.error_offset,
                                 want.bytes_missing, want.char_count, want.last_result,
                                 m_tdata[31:0], m_tuser, m_tdata[47:32], m_tdata[50:48],
                                 m_tdata[66:51], m_tlast, m_tdata[M_DATA_W-1:67]));
        end
        pick_idle(sink_calm, stall);
        m_tready <= (stall == 0);
      end else if (stall > 0) begin
        stall--;
        m_tready <= (stall == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] str [$];
    int         sent;
    int         nchar;
    int         pick;
    int         len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // String A: ASCII extremes, 2/3-byte characters, largest 6-byte value at string end
    script_row(8'h00, 1'b0, 1'b1, fixed_result(32'h0, ST_CHAR, 16'd0, 3'd0, 16'd1, 1'b0));
    script_row(8'h7F, 1'b0, 1'b1, fixed_result(32'h7F, ST_CHAR, 16'd0, 3'd0, 16'd2, 1'b0));
    script_row(8'hC2, 1'b0);
    script_row(8'hA9, 1'b0);
    script_row(8'hE2, 1'b0);
    script_row(8'h82, 1'b0);
    script_row(8'hAC, 1'b0);
    script_row(8'hFF, 1'b0);
    repeat (4) script_row(8'hBF, 1'b0);
    script_row(8'hBF, 1'b1, 1'b1,
               fixed_result(32'hFFFF_FFFF, ST_CHAR, 16'd0, 3'd0, 16'd5, 1'b1));
    // String B: stray continuation first, the rest is dropped through string end
    script_row(8'h80, 1'b0, 1'b1, fixed_result(32'h0, ST_INVALID, 16'd0, 3'd0, 16'd0, 1'b1));
    script_row(8'h41, 1'b1);
    // String C: ASCII and a 4-byte character, then a 5-byte lead broken by ASCII
    script_row(8'h41, 1'b0);
    script_row(8'hF0, 1'b0);
    script_row(8'h9F, 1'b0);
    script_row(8'h98, 1'b0);
    script_row(8'h80, 1'b0);
    script_row(8'hF8, 1'b0);
    script_row(8'h88, 1'b0);
    script_row(8'h41, 1'b0, 1'b1, fixed_result(32'h0, ST_INVALID, 16'd5, 3'd0, 16'd2, 1'b1));
    script_row(8'hC3, 1'b1);
    // String D: lead alone at string end, truncated
    script_row(8'hE2, 1'b1, 1'b1, fixed_result(32'h0, ST_TRUNCATED, 16'd0, 3'd2, 16'd0, 1'b1));

    foreach (script[i]) send_byte(script[i].b, script[i].eos, script[i].typed, script[i].want);

    // One long string at full rate on both sides,
    // then a stray continuation reported at its offset
    steady = 1'b1;
    for (int i = 0; i < LONG_ASCII; i++) send_byte(8'($urandom_range(0, 127)), 1'b0);
    send_byte(PAT_CONT, 1'b0);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b1);
    steady = 1'b0;

    // Random strings: mostly well-formed characters, some noise bytes,
    // some strings that end inside an open sequence
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      str.delete();
      nchar = $urandom_range(1, 12);
      for (int c = 0; c < nchar; c++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          str.push_back(8'($urandom));
        end else begin
          if (pick < 45) len = 1;
          else if (pick < 63) len = 2;
          else if (pick < 76) len = 3;
          else if (pick < 85) len = 4;
          else if (pick < 93) len = 5;
          else len = 6;
          str.push_back(lead_for(len));
          for (int k = 1; k < len; k++) str.push_back(cont_byte());
        end
      end
      if ($urandom_range(0, 99) < 12) begin
        len = $urandom_range(2, 6);
        str.push_back(lead_for(len));
        repeat ($urandom_range(0, len - 2)) str.push_back(cont_byte());
      end
      foreach (str[j]) send_byte(str[j], j == str.size() - 1);
      sent += str.size();
    end
    s_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/utf8d_pkg.sv
design/utf8d_front.sv
design/utf8d_queue.sv
design/utf8d_back.sv
design/utf8_stream_decoder.sv
tb/tb_utf8_stream_decoder.sv
